### rtl/core/bacp_pkg.sv
package bacp_pkg;

    localparam int CHANNELS         = 9;
    localparam int TENSION_CHANNELS = 6;
    localparam int MAX_FRAMES       = 32;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_CH_W = 3;
    localparam int GAIN_W    = 32;
    localparam int OFFSET_W  = 32;
    localparam int CAL_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int CH_W      = 4;
    localparam int BLK_W     = 16;
    localparam int FPB_W     = 6;

    localparam logic [FPB_W-1:0] FPB_RESET = FPB_W'(20);

    localparam int FC_W    = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W   = SAMPLE_W + FC_W;
    localparam int AW      = $clog2(CHANNELS);
    localparam int CW      = (TENSION_CHANNELS > 1) ? $clog2(TENSION_CHANNELS) : 1;
    localparam int NW      = (FC_W > FPB_W) ? FC_W : FPB_W;
    localparam int PROD_W  = SAMPLE_W + GAIN_W;
    localparam int SWORD_W = CAL_W + SUM_W;
    localparam int CWORD_W = GAIN_W + OFFSET_W;

    typedef struct packed {
        logic signed [CAL_W-1:0] cal;
        logic signed [CAL_W-1:0] peak;
    } t_cal_res;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ACC  = 7'b0000010,
        S_RD   = 7'b0000100,
        S_LOAD = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_MUL  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    // frames per block clamped to 1..MAX_FRAMES
    function automatic logic [NW-1:0] eff_frames(input logic [FPB_W-1:0] v);
        logic [NW-1:0] e;
        e = NW'(v);
        if (e == '0) begin
            e = NW'(1);
        end else if (e > NW'(MAX_FRAMES)) begin
            e = NW'(MAX_FRAMES);
        end
        return e;
    endfunction

endpackage

### rtl/core/bacp_in_if.sv
interface bacp_in_if import bacp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic signed [SAMPLE_W-1:0] sample;
    logic [COEF_CH_W-1:0]       coef_channel;
    logic signed [GAIN_W-1:0]   coef_gain;
    logic signed [OFFSET_W-1:0] coef_offset;

    modport source (output valid, mode, sample, coef_channel, coef_gain, coef_offset,
                    input ready);
    modport sink   (input valid, mode, sample, coef_channel, coef_gain, coef_offset,
                    output ready);
endinterface

### rtl/core/bacp_out_if.sv
interface bacp_out_if import bacp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] average;
    logic signed [CAL_W-1:0]    calibrated;
    logic signed [CAL_W-1:0]    peak;
    logic [BLK_W-1:0]           block_index;
    logic                       last;

    modport source (output valid, channel, average, calibrated, peak, block_index, last,
                    input ready);
    modport sink   (input valid, channel, average, calibrated, peak, block_index, last,
                    output ready);
endinterface

### rtl/core/bacp_cfg_if.sv
interface bacp_cfg_if import bacp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [FPB_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/core/bacp_ram.sv
module bacp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/bacp_div.sv
module bacp_div import bacp_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [SUM_W-1:0]    i_dividend,
    input  logic [FC_W-1:0]            i_divisor,
    output logic                       o_done,
    output logic signed [SAMPLE_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [FC_W-1:0]  r_rem;
    logic [SUM_W-1:0] r_q;
    logic [FC_W-1:0]  r_div;
    logic             r_neg;

    logic [FC_W:0]    rem_sh;
    logic [FC_W:0]    diff;
    logic             ge;
    logic [SUM_W-1:0] mag;

    assign rem_sh = {r_rem, r_q[SUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_div};
    assign diff   = rem_sh - {1'b0, r_div};
    assign mag    = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= mag;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            r_rem <= ge ? diff[FC_W-1:0] : rem_sh[FC_W-1:0];
            r_q   <= {r_q[SUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q[SAMPLE_W-1:0]) : $signed(r_q[SAMPLE_W-1:0]);

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> $past(r_busy);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy)
        else $error("divider done without a running division");

    property p_no_restart;
        @(posedge i_clk) disable iff (!i_rst_n) r_busy |-> !i_start;
    endproperty
    a_no_restart: assert property (p_no_restart)
        else $error("divider restarted while busy");

    property p_rem_below_div;
        @(posedge i_clk) disable iff (!i_rst_n) r_busy |-> (r_rem < r_div);
    endproperty
    a_rem_below_div: assert property (p_rem_below_div)
        else $error("partial remainder not below divisor");
endmodule

### rtl/core/bacp_cal.sv
module bacp_cal import bacp_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic signed [SAMPLE_W-1:0] i_avg,
    input  logic signed [GAIN_W-1:0]   i_gain,
    input  logic signed [OFFSET_W-1:0] i_offset,
    input  logic signed [CAL_W-1:0]    i_peak,
    output t_cal_res                   o_res
);
    localparam logic signed [CAL_W-1:0] CAL_MAX = {1'b0, {(CAL_W-1){1'b1}}};
    localparam logic signed [CAL_W-1:0] CAL_MIN = {1'b1, {(CAL_W-1){1'b0}}};

    logic signed [PROD_W-1:0]         r_prod;
    logic signed [PROD_W-FRAC_W-1:0]  scaled;
    logic signed [CAL_W:0]            total;
    logic signed [CAL_W-1:0]          cal;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= i_avg * i_gain;
        end
    end

    // floor shift, then offset with saturation
    assign scaled = r_prod[PROD_W-1:FRAC_W];
    assign total  = (CAL_W+1)'(scaled) + (CAL_W+1)'(i_offset);

    always_comb begin
        if (total[CAL_W] != total[CAL_W-1]) begin
            cal = total[CAL_W] ? CAL_MIN : CAL_MAX;
        end else begin
            cal = total[CAL_W-1:0];
        end
        o_res.cal  = cal;
        o_res.peak = (cal > i_peak) ? cal : i_peak;
    end
endmodule

### rtl/core/block_average_calibrate_peak.sv
// Channel  Dir  Handshake      Payload
// i_in     in   valid/ready    mode, sample, coef_channel, coef_gain, coef_offset
// o_res    out  valid/ready    channel, average, calibrated, peak, block_index, last
// i_cfg    in   valid/ready    data = frames_per_block (always ready)
//
// Sample transaction: accept, then read-modify-write of the sum/peak RAM.
// Coefficient transaction: written to the coefficient RAM on accept. Block end: per
// channel RAM read, serial divider one quotient bit per cycle, multiply, output,
// plus any output stall; o_res holds one result in a register.
// Reset: sums and peaks read as zero through per-entry valid bits, no clearing pass;
// frames_per_block resets to 20.
module block_average_calibrate_peak import bacp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bacp_in_if.sink    i_in,
    bacp_out_if.source o_res,
    bacp_cfg_if.sink   i_cfg
);
    t_state                     r_state;
    logic [AW-1:0]              r_slot;
    logic [AW-1:0]              r_ch;
    logic [FC_W-1:0]            r_fc;
    logic [FPB_W-1:0]           r_frames;
    logic [BLK_W-1:0]           r_block;
    logic [CHANNELS-1:0]        r_valid;
    logic                       r_rd_ok;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [CAL_W-1:0]    r_peak;
    logic signed [GAIN_W-1:0]   r_gain;
    logic signed [OFFSET_W-1:0] r_off;

    logic                       r_out_valid;
    logic [CH_W-1:0]            r_out_channel;
    logic signed [SAMPLE_W-1:0] r_out_average;
    logic signed [CAL_W-1:0]    r_out_calibrated;
    logic signed [CAL_W-1:0]    r_out_peak;
    logic [BLK_W-1:0]           r_out_block;
    logic                       r_out_last;

    logic                       in_acc;
    logic                       coef_we;
    logic [CWORD_W-1:0]         coef_rdata;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [SWORD_W-1:0]         ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [SWORD_W-1:0]         ram_rdata;
    logic signed [SUM_W-1:0]    sum_rd;
    logic signed [CAL_W-1:0]    peak_rd;
    logic signed [SUM_W-1:0]    sum_new;
    logic                       slot_last;
    logic [FC_W-1:0]            fc_next;
    logic                       block_done;
    logic                       ch_last;
    logic                       is_tension;
    logic                       out_load;
    logic                       div_done;
    logic signed [SAMPLE_W-1:0] div_q;
    t_cal_res                   cal_res;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign coef_we     = in_acc && i_in.mode && (int'(i_in.coef_channel) < TENSION_CHANNELS);

    assign sum_rd  = r_rd_ok ? $signed(ram_rdata[SUM_W-1:0]) : '0;
    assign peak_rd = r_rd_ok ? $signed(ram_rdata[SWORD_W-1:SUM_W]) : '0;
    assign sum_new = sum_rd + SUM_W'(r_sample);

    assign slot_last  = (r_slot == AW'(CHANNELS - 1));
    assign fc_next    = r_fc + FC_W'(1);
    assign block_done = slot_last && (NW'(fc_next) >= eff_frames(r_frames));
    assign ch_last    = (r_ch == AW'(CHANNELS - 1));
    assign is_tension = int'(r_ch) < TENSION_CHANNELS;
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || o_res.ready);

    assign ram_raddr = (r_state == S_RD) ? r_ch : r_slot;
    assign ram_we    = (r_state == S_ACC) || out_load;
    assign ram_waddr = (r_state == S_ACC) ? r_slot : r_ch;
    assign ram_wdata = (r_state == S_ACC) ? {peak_rd, sum_new}
                     : {(is_tension ? cal_res.peak : r_peak), {SUM_W{1'b0}}};

    bacp_ram #(.WIDTH(SWORD_W), .DEPTH(CHANNELS)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bacp_ram #(.WIDTH(CWORD_W), .DEPTH(TENSION_CHANNELS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (CW'(i_in.coef_channel)),
        .i_wdata ({i_in.coef_gain, i_in.coef_offset}),
        .i_raddr (CW'(r_ch)),
        .o_rdata (coef_rdata)
    );

    bacp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_LOAD),
        .i_dividend (sum_rd),
        .i_divisor  (r_fc),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    bacp_cal u_cal (
        .i_clk    (i_clk),
        .i_load   (r_state == S_MUL),
        .i_avg    (div_q),
        .i_gain   (r_gain),
        .i_offset (r_off),
        .i_peak   (r_peak),
        .o_res    (cal_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_ch        <= '0;
            r_fc        <= '0;
            r_frames    <= FPB_RESET;
            r_block     <= '0;
            r_valid     <= '0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_ok <= r_valid[ram_raddr];
            if (i_cfg.valid) begin
                r_frames <= i_cfg.data;
            end
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && !i_in.mode) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_slot <= slot_last ? '0 : r_slot + AW'(1);
                    if (slot_last) begin
                        r_fc <= fc_next;
                    end
                    r_state <= block_done ? S_RD : S_IDLE;
                end
                S_RD: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        if (ch_last) begin
                            r_ch    <= '0;
                            r_fc    <= '0;
                            r_block <= r_block + BLK_W'(1);
                            r_state <= S_IDLE;
                        end else begin
                            r_ch    <= r_ch + AW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_in.sample;
        end
        if (r_state == S_LOAD) begin
            r_peak <= peak_rd;
            r_gain <= $signed(coef_rdata[CWORD_W-1:OFFSET_W]);
            r_off  <= $signed(coef_rdata[OFFSET_W-1:0]);
        end
        if (out_load) begin
            r_out_channel    <= CH_W'(r_ch);
            r_out_average    <= div_q;
            r_out_calibrated <= is_tension ? cal_res.cal : CAL_W'(div_q);
            r_out_peak       <= is_tension ? cal_res.peak : '0;
            r_out_block      <= r_block;
            r_out_last       <= ch_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.channel     = r_out_channel;
    assign o_res.average     = r_out_average;
    assign o_res.calibrated  = r_out_calibrated;
    assign o_res.peak        = r_out_peak;
    assign o_res.block_index = r_out_block;
    assign o_res.last        = r_out_last;

    property p_accept_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_in.valid && i_in.ready) |-> (r_state == S_IDLE);
    endproperty
    a_accept_idle: assert property (p_accept_idle)
        else $error("transaction accepted outside idle");

    property p_slot_range;
        @(posedge i_clk) disable iff (!i_rst_n)
            (int'(r_slot) < CHANNELS) && (int'(r_ch) < CHANNELS);
    endproperty
    a_slot_range: assert property (p_slot_range)
        else $error("channel index out of range");

    property p_block_end;
        @(posedge i_clk) disable iff (!i_rst_n)
            (out_load && ch_last) |=> (r_state == S_IDLE) && (r_fc == '0) && o_res.last;
    endproperty
    a_block_end: assert property (p_block_end)
        else $error("block did not close after last channel");

    property p_div_in_state;
        @(posedge i_clk) disable iff (!i_rst_n) div_done |-> (r_state == S_DIV);
    endproperty
    a_div_in_state: assert property (p_div_in_state)
        else $error("divider finished outside divide state");
endmodule
